FILE: sv/drc_pkg.sv
// Shared types, constants and codes for the grid ray caster.
`default_nettype none

package drc_pkg;

    // Default values of the top-level parameters.
    localparam int MAP_DIM_DEF   = 32;
    localparam int TEX_SIZE_DEF  = 32;
    localparam int MAX_STEPS_DEF = 64;

    // Field and datapath widths.
    localparam int POS_W      = 21;
    localparam int DIR_W      = 16;
    localparam int SIZE_W     = 11;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam int COL_W      = 10;
    localparam int CIDX_W     = 5;
    localparam int CVAL_W     = 8;
    localparam int CAM_W      = 27;
    localparam int RAY_W      = 28;
    localparam int DELTA_W    = 26;
    localparam int SIDE_W     = 34;
    localparam int MAPC_W     = 8;
    localparam int COLH_W     = 24;
    localparam int STEP_W     = 22;
    localparam int TP_W       = 32;
    localparam int ROW_W      = 10;
    localparam int TEXC_W     = 5;
    localparam int TEXI_W     = 9;
    localparam int FRAC_W     = 16;
    localparam int TSUM_W     = 25;
    localparam int MUL_W      = 29;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int DIV_NUM_W  = 31;
    localparam int DIV_DEN_W  = 28;

    // Saturation limits.
    localparam logic [DELTA_W-1:0] DIST_MAX = '1;
    localparam logic [COLH_W-1:0]  COLH_MAX = '1;
    localparam logic [STEP_W-1:0]  STEP_MAX = '1;
    localparam logic [SIZE_W-1:0]  SIZE_MAX = SIZE_W'(1024);

    // Input item operation codes.
    localparam logic OPC_WRITE = 1'b0;
    localparam logic OPC_CAST  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_POS_X   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_POS_Y   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_X = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_Y = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = CFG_IDX_W'(7);

    // One input item.
    typedef struct packed {
        logic              opcode;
        logic [CIDX_W-1:0] cell_x;
        logic [CIDX_W-1:0] cell_y;
        logic [CVAL_W-1:0] cell_value;
        logic [COL_W-1:0]  column;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [COL_W-1:0]   out_column;
        logic [CIDX_W-1:0]  hit_x;
        logic [CIDX_W-1:0]  hit_y;
        logic               hit_side;
        logic [CVAL_W-1:0]  tex_index;
        logic [TEXC_W-1:0]  tex_column;
        logic [ROW_W-1:0]   span_start;
        logic [ROW_W-1:0]   span_end;
        logic [DELTA_W-1:0] wall_distance;
        logic [STEP_W-1:0]  tex_step;
        logic [TP_W-1:0]    tex_start;
        logic               escaped;
    } t_out_item;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_WRITE,
        OP_TAKE,
        OP_DIV_START,
        OP_CAM,
        OP_RAYX,
        OP_RAYY,
        OP_DX,
        OP_DY,
        OP_INIT,
        OP_SIDEX,
        OP_SIDEY,
        OP_STEP,
        OP_DIST,
        OP_COLH,
        OP_WALL,
        OP_TSTEP,
        OP_TP,
        OP_LOAD_HIT,
        OP_LOAD_ESC
    } t_op;

    // Divider operand selection.
    typedef enum logic [2:0] {
        DIV_CAM,
        DIV_DX,
        DIV_DY,
        DIV_COLH,
        DIV_STEP
    } t_div_sel;

    // Multiplier operand selection.
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_RX,
        MUL_RY,
        MUL_SX,
        MUL_SY,
        MUL_WALL,
        MUL_TP
    } t_mul_sel;

    typedef struct packed {
        t_op      op;
        t_div_sel div_sel;
        t_mul_sel mul_sel;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic div_done;
        logic start_out;
        logic out_free;
        logic ray_x_zero;
        logic ray_y_zero;
        logic dist_zero;
        logic colh_zero;
        logic in_bounds;
        logic cell_hit;
        logic steps_done;
    } t_stat;

endpackage

`default_nettype wire

FILE: sv/drc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module drc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: sv/drc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module drc_div
    import drc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [DIV_NUM_W-1:0] i_num,
    input  wire logic [DIV_DEN_W-1:0] i_den,
    output logic                      o_done,
    output logic      [DIV_NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(DIV_NUM_W);

    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W:0]   trial;
    logic                 ge;

    // Shift the next numerator bit into the partial remainder.
    assign trial = {r_rem, o_quot[DIV_NUM_W-1]};
    assign ge    = trial >= {1'b0, r_den};

    // Control: busy flag, bit counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den  <= i_den;
            r_rem  <= '0;
            o_quot <= i_num;
        end else if (r_busy) begin
            r_rem  <= ge ? DIV_DEN_W'(trial - {1'b0, r_den}) : trial[DIV_DEN_W-1:0];
            o_quot <= {o_quot[DIV_NUM_W-2:0], ge};
        end
    end

endmodule

`default_nettype wire

FILE: sv/drc_dpath.sv
// Datapath of the ray caster: registers, map memory, multiplier and divider.
`default_nettype none

module drc_dpath
    import drc_pkg::*;
#(
    parameter int MAP_DIM   = MAP_DIM_DEF,
    parameter int TEX_SIZE  = TEX_SIZE_DEF,
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_stat                      o_stat,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DEPTH  = MAP_DIM * MAP_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int N_W    = $clog2(MAX_STEPS + 1);

    // Configuration registers.
    logic        [POS_W-1:0]  r_pos_x, r_pos_y;
    logic signed [DIR_W-1:0]  r_dir_x, r_dir_y, r_plane_x, r_plane_y;
    logic        [SIZE_W-1:0] r_width, r_height;

    // Per-cast working registers.
    logic        [COL_W-1:0]   r_col;
    logic signed [CAM_W-1:0]   r_cam;
    logic signed [RAY_W-1:0]   r_rdx, r_rdy;
    logic        [DELTA_W-1:0] r_dx, r_dy;
    logic        [SIDE_W-1:0]  r_sx, r_sy;
    logic signed [MAPC_W-1:0]  r_mx, r_my;
    logic                      r_side;
    logic        [N_W-1:0]     r_n;
    logic        [CVAL_W-1:0]  r_cell;
    logic        [DELTA_W-1:0] r_dist;
    logic        [COLH_W-1:0]  r_colh;
    logic        [ROW_W-1:0]   r_ds, r_de;
    logic        [TEXC_W-1:0]  r_texc;
    logic        [STEP_W-1:0]  r_step;
    logic        [TP_W-1:0]    r_tp;
    logic signed [PROD_W-1:0]  r_prod;
    logic        [ADDR_W-1:0]  r_clr;

    // Combinational helpers.
    logic        [SIZE_W-1:0]         w_c, h_c;
    logic signed [MUL_W-1:0]          mul_a, mul_b;
    logic        [DIV_NUM_W-1:0]      div_num, div_quot;
    logic        [DIV_DEN_W-1:0]      div_den, rdx_mag, rdy_mag;
    logic                             div_done;
    logic        [FRAC_W:0]           fxp, fyp;
    logic        [ROW_W-1:0]          hh;
    logic        [COLH_W-2:0]         ch;
    logic        [ROW_W-1:0]          ds_c;
    logic        [COLH_W-1:0]         de_sum;
    logic        [ROW_W-1:0]          de_c;
    logic        [TSUM_W-1:0]         tsum;
    logic        [SIDE_W-1:0]         dist_diff;
    logic        [FRAC_W-1:0]         frac;
    logic        [FRAC_W+TEXI_W-1:0]  tex_prod;
    logic        [TEXI_W-1:0]         tex_raw;
    logic                             mirror;
    logic        [MAPC_W-1:0]         step_x, step_y;
    logic                             ram_we;
    logic        [ADDR_W-1:0]         ram_waddr, ram_raddr;
    logic        [CVAL_W-1:0]         ram_wdata, ram_rdata;
    logic                             cell_in_map;

    assign o_cfg_ready = 1'b1;

    // Screen sizes clamped to the range 1 to 1024.
    assign w_c = (r_width == '0) ? SIZE_W'(1) : ((r_width > SIZE_MAX) ? SIZE_MAX : r_width);
    assign h_c = (r_height == '0) ? SIZE_W'(1) : ((r_height > SIZE_MAX) ? SIZE_MAX : r_height);

    // Ray magnitudes for the delta divisions.
    assign rdx_mag = r_rdx[RAY_W-1] ? DIV_DEN_W'(-r_rdx) : DIV_DEN_W'(r_rdx);
    assign rdy_mag = r_rdy[RAY_W-1] ? DIV_DEN_W'(-r_rdy) : DIV_DEN_W'(r_rdy);

    // Position fraction toward the step direction.
    assign fxp = r_rdx[RAY_W-1] ? {1'b0, r_pos_x[FRAC_W-1:0]}
                                : (FRAC_W+1)'(65536) - {1'b0, r_pos_x[FRAC_W-1:0]};
    assign fyp = r_rdy[RAY_W-1] ? {1'b0, r_pos_y[FRAC_W-1:0]}
                                : (FRAC_W+1)'(65536) - {1'b0, r_pos_y[FRAC_W-1:0]};

    // Span arithmetic on half height and half column height.
    assign hh     = h_c[SIZE_W-1:1];
    assign ch     = r_colh[COLH_W-1:1];
    assign ds_c   = (ch > (COLH_W-1)'(hh)) ? '0 : ROW_W'(hh - ch[ROW_W-1:0]);
    assign de_sum = COLH_W'(ch) + COLH_W'(hh);
    assign de_c   = (de_sum >= COLH_W'(h_c)) ? ROW_W'(h_c - SIZE_W'(1)) : de_sum[ROW_W-1:0];
    assign tsum   = TSUM_W'(ch) + TSUM_W'(r_ds) - TSUM_W'(hh);

    // Side distance of the last step minus its delta.
    assign dist_diff = r_side ? (r_sy - SIDE_W'(r_dy)) : (r_sx - SIDE_W'(r_dx));

    // Hit point fraction, texture column and mirroring rule.
    assign frac     = (r_side ? r_pos_x[FRAC_W-1:0] : r_pos_y[FRAC_W-1:0])
                      + r_prod[14 +: FRAC_W];
    assign tex_prod = (FRAC_W+TEXI_W)'(frac) * (FRAC_W+TEXI_W)'(TEX_SIZE);
    assign tex_raw  = tex_prod[FRAC_W +: TEXI_W];
    assign mirror   = (!r_side && !r_rdx[RAY_W-1] && (r_rdx != '0))
                      || (r_side && r_rdy[RAY_W-1]);

    // Grid step direction.
    assign step_x = r_rdx[RAY_W-1] ? '1 : MAPC_W'(1);
    assign step_y = r_rdy[RAY_W-1] ? '1 : MAPC_W'(1);

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mul_sel)
            MUL_RX: begin
                mul_a = MUL_W'(r_plane_x);
                mul_b = MUL_W'(r_cam);
            end
            MUL_RY: begin
                mul_a = MUL_W'(r_plane_y);
                mul_b = MUL_W'(r_cam);
            end
            MUL_SX: begin
                mul_a = $signed(MUL_W'(fxp));
                mul_b = $signed(MUL_W'(r_dx));
            end
            MUL_SY: begin
                mul_a = $signed(MUL_W'(fyp));
                mul_b = $signed(MUL_W'(r_dy));
            end
            MUL_WALL: begin
                mul_a = $signed(MUL_W'(r_dist));
                mul_b = r_side ? MUL_W'(r_rdx) : MUL_W'(r_rdy);
            end
            MUL_TP: begin
                mul_a = $signed(MUL_W'(tsum));
                mul_b = $signed(MUL_W'(r_step));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Divider operand selection.
    always_comb begin
        div_num = '0;
        div_den = '0;
        unique case (i_cmd.div_sel)
            DIV_CAM: begin
                div_num = DIV_NUM_W'({r_col, 15'd0});
                div_den = DIV_DEN_W'(w_c);
            end
            DIV_DX: begin
                div_num = DIV_NUM_W'(31'h4000_0000);
                div_den = rdx_mag;
            end
            DIV_DY: begin
                div_num = DIV_NUM_W'(31'h4000_0000);
                div_den = rdy_mag;
            end
            DIV_COLH: begin
                div_num = DIV_NUM_W'({h_c, 16'd0});
                div_den = DIV_DEN_W'(r_dist);
            end
            DIV_STEP: begin
                div_num = DIV_NUM_W'(TEX_SIZE * 65536);
                div_den = DIV_DEN_W'(r_colh);
            end
            default: begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    drc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_DIV_START),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Map memory ports: clearing sweep or cell write, and the walk read.
    assign cell_in_map = (int'(i_in_data.cell_x) < MAP_DIM) && (int'(i_in_data.cell_y) < MAP_DIM);
    assign ram_we      = (i_cmd.op == OP_CLEAR) || ((i_cmd.op == OP_WRITE) && cell_in_map);
    assign ram_waddr   = (i_cmd.op == OP_CLEAR) ? r_clr
                         : ADDR_W'(int'(i_in_data.cell_x) * MAP_DIM + int'(i_in_data.cell_y));
    assign ram_wdata   = (i_cmd.op == OP_CLEAR) ? '0 : i_in_data.cell_value;
    assign ram_raddr   = ADDR_W'(int'(r_mx[MAPC_W-2:0]) * MAP_DIM + int'(r_my[MAPC_W-2:0]));

    drc_ram #(
        .WIDTH (CVAL_W),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Status back to the controller.
    always_comb begin
        o_stat.clear_done = (r_clr == ADDR_W'(DEPTH - 1));
        o_stat.div_done   = div_done;
        o_stat.start_out  = (int'(r_pos_x[POS_W-1:FRAC_W]) >= MAP_DIM)
                            || (int'(r_pos_y[POS_W-1:FRAC_W]) >= MAP_DIM);
        o_stat.out_free   = !o_out_valid || i_out_ready;
        o_stat.ray_x_zero = (r_rdx == '0);
        o_stat.ray_y_zero = (r_rdy == '0);
        o_stat.dist_zero  = (r_dist == '0);
        o_stat.colh_zero  = (r_colh == '0);
        o_stat.in_bounds  = !r_mx[MAPC_W-1] && (int'(r_mx) < MAP_DIM)
                            && !r_my[MAPC_W-1] && (int'(r_my) < MAP_DIM);
        o_stat.cell_hit   = (ram_rdata != '0);
        o_stat.steps_done = (r_n == N_W'(MAX_STEPS));
    end

    // Configuration registers, clearing counter and result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x     <= POS_W'(786432);
            r_pos_y     <= POS_W'(786432);
            r_dir_x     <= -DIR_W'(16384);
            r_dir_y     <= '0;
            r_plane_x   <= '0;
            r_plane_y   <= DIR_W'(10813);
            r_width     <= SIZE_W'(640);
            r_height    <= SIZE_W'(480);
            r_clr       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_POS_X:   r_pos_x   <= i_cfg_data[POS_W-1:0];
                    CFG_POS_Y:   r_pos_y   <= i_cfg_data[POS_W-1:0];
                    CFG_DIR_X:   r_dir_x   <= i_cfg_data[DIR_W-1:0];
                    CFG_DIR_Y:   r_dir_y   <= i_cfg_data[DIR_W-1:0];
                    CFG_PLANE_X: r_plane_x <= i_cfg_data[DIR_W-1:0];
                    CFG_PLANE_Y: r_plane_y <= i_cfg_data[DIR_W-1:0];
                    CFG_WIDTH:   r_width   <= i_cfg_data[SIZE_W-1:0];
                    CFG_HEIGHT:  r_height  <= i_cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_CLEAR) begin
                r_clr <= r_clr + ADDR_W'(1);
            end
            if (i_cmd.op == OP_LOAD_HIT || i_cmd.op == OP_LOAD_ESC) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // Working registers, driven by the controller's operation.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (i_cmd.op)
            OP_TAKE: r_col <= i_in_data.column;
            OP_CAM:  r_cam <= CAM_W'(div_quot) - CAM_W'(16384);
            OP_RAYX: r_rdx <= RAY_W'(r_dir_x) + $signed(r_prod[14 +: RAY_W]);
            OP_RAYY: r_rdy <= RAY_W'(r_dir_y) + $signed(r_prod[14 +: RAY_W]);
            OP_DX: begin
                if (r_rdx == '0 || div_quot > DIV_NUM_W'(DIST_MAX)) begin
                    r_dx <= DIST_MAX;
                end else begin
                    r_dx <= div_quot[DELTA_W-1:0];
                end
            end
            OP_DY: begin
                if (r_rdy == '0 || div_quot > DIV_NUM_W'(DIST_MAX)) begin
                    r_dy <= DIST_MAX;
                end else begin
                    r_dy <= div_quot[DELTA_W-1:0];
                end
            end
            OP_INIT: begin
                r_mx <= MAPC_W'(r_pos_x[POS_W-1:FRAC_W]);
                r_my <= MAPC_W'(r_pos_y[POS_W-1:FRAC_W]);
                r_n  <= '0;
            end
            OP_SIDEX: r_sx <= SIDE_W'(r_prod[16 +: DELTA_W+1]);
            OP_SIDEY: r_sy <= SIDE_W'(r_prod[16 +: DELTA_W+1]);
            OP_STEP: begin
                // A tie between the side distances steps in y.
                if (r_sx < r_sy) begin
                    r_sx   <= r_sx + SIDE_W'(r_dx);
                    r_mx   <= r_mx + step_x;
                    r_side <= 1'b0;
                end else begin
                    r_sy   <= r_sy + SIDE_W'(r_dy);
                    r_my   <= r_my + step_y;
                    r_side <= 1'b1;
                end
                r_n <= r_n + N_W'(1);
            end
            OP_DIST: begin
                r_cell <= ram_rdata;
                r_dist <= (dist_diff > SIDE_W'(DIST_MAX)) ? DIST_MAX
                                                          : dist_diff[DELTA_W-1:0];
            end
            OP_COLH: begin
                if (r_dist == '0 || div_quot > DIV_NUM_W'(COLH_MAX)) begin
                    r_colh <= COLH_MAX;
                end else begin
                    r_colh <= div_quot[COLH_W-1:0];
                end
            end
            OP_WALL: begin
                r_ds   <= ds_c;
                r_de   <= de_c;
                r_texc <= mirror ? TEXC_W'(TEXI_W'(TEX_SIZE - 1) - tex_raw)
                                 : tex_raw[TEXC_W-1:0];
            end
            OP_TSTEP: begin
                if (r_colh == '0 || div_quot > DIV_NUM_W'(STEP_MAX)) begin
                    r_step <= STEP_MAX;
                end else begin
                    r_step <= div_quot[STEP_W-1:0];
                end
            end
            OP_TP: begin
                r_tp <= (r_prod[PROD_W-1:TP_W] != '0) ? '1 : r_prod[TP_W-1:0];
            end
            default: ;
        endcase
    end

    // Result register; an escaped result carries only its column and the flag.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD_HIT) begin
            o_out_data.out_column    <= r_col;
            o_out_data.hit_x         <= r_mx[CIDX_W-1:0];
            o_out_data.hit_y         <= r_my[CIDX_W-1:0];
            o_out_data.hit_side      <= r_side;
            o_out_data.tex_index     <= r_cell - CVAL_W'(1);
            o_out_data.tex_column    <= r_texc;
            o_out_data.span_start    <= r_ds;
            o_out_data.span_end      <= r_de;
            o_out_data.wall_distance <= r_dist;
            o_out_data.tex_step      <= r_step;
            o_out_data.tex_start     <= r_tp;
            o_out_data.escaped       <= 1'b0;
        end else if (i_cmd.op == OP_LOAD_ESC) begin
            o_out_data.out_column    <= r_col;
            o_out_data.hit_x         <= '0;
            o_out_data.hit_y         <= '0;
            o_out_data.hit_side      <= 1'b0;
            o_out_data.tex_index     <= '0;
            o_out_data.tex_column    <= '0;
            o_out_data.span_start    <= '0;
            o_out_data.span_end      <= '0;
            o_out_data.wall_distance <= '0;
            o_out_data.tex_step      <= '0;
            o_out_data.tex_start     <= '0;
            o_out_data.escaped       <= 1'b1;
        end
    end

endmodule

`default_nettype wire

FILE: sv/drc_ctrl.sv
// Controller state machine sequencing the ray caster datapath.
`default_nettype none

module drc_ctrl
    import drc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire logic  i_in_opcode,
    input  wire t_stat i_stat,
    output logic       o_in_ready,
    output t_cmd       o_cmd
);

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_CAM_GO,
        S_CAM_WAIT,
        S_RX_MUL,
        S_RX,
        S_RY_MUL,
        S_RY,
        S_DX_GO,
        S_DX_WAIT,
        S_DY_GO,
        S_DY_WAIT,
        S_INIT,
        S_SX_MUL,
        S_SX,
        S_SY_MUL,
        S_SY,
        S_STEP,
        S_CHECK,
        S_TEST,
        S_DIST,
        S_COLH_GO,
        S_COLH_WAIT,
        S_WALL_MUL,
        S_WALL,
        S_TSTEP_GO,
        S_TSTEP_WAIT,
        S_TP_MUL,
        S_TP,
        S_OUT,
        S_ESC
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and datapath command.
    always_comb begin
        n_state = r_state;
        o_cmd   = '{op: OP_NONE, div_sel: DIV_CAM, mul_sel: MUL_NONE};
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                if (i_stat.clear_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_opcode == OPC_CAST) begin
                        o_cmd.op = OP_TAKE;
                        n_state  = S_CAM_GO;
                    end else begin
                        o_cmd.op = OP_WRITE;
                    end
                end
            end
            S_CAM_GO: begin
                o_cmd.op      = OP_DIV_START;
                o_cmd.div_sel = DIV_CAM;
                n_state       = S_CAM_WAIT;
            end
            S_CAM_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.op = OP_CAM;
                    n_state  = S_RX_MUL;
                end
            end
            S_RX_MUL: begin
                o_cmd.mul_sel = MUL_RX;
                n_state       = S_RX;
            end
            S_RX: begin
                o_cmd.op = OP_RAYX;
                n_state  = S_RY_MUL;
            end
            S_RY_MUL: begin
                o_cmd.mul_sel = MUL_RY;
                n_state       = S_RY;
            end
            S_RY: begin
                o_cmd.op = OP_RAYY;
                n_state  = S_DX_GO;
            end
            S_DX_GO: begin
                if (i_stat.ray_x_zero) begin
                    o_cmd.op = OP_DX;
                    n_state  = S_DY_GO;
                end else begin
                    o_cmd.op      = OP_DIV_START;
                    o_cmd.div_sel = DIV_DX;
                    n_state       = S_DX_WAIT;
                end
            end
            S_DX_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.op = OP_DX;
                    n_state  = S_DY_GO;
                end
            end
            S_DY_GO: begin
                if (i_stat.ray_y_zero) begin
                    o_cmd.op = OP_DY;
                    n_state  = S_INIT;
                end else begin
                    o_cmd.op      = OP_DIV_START;
                    o_cmd.div_sel = DIV_DY;
                    n_state       = S_DY_WAIT;
                end
            end
            S_DY_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.op = OP_DY;
                    n_state  = S_INIT;
                end
            end
            S_INIT: begin
                if (i_stat.start_out) begin
                    n_state = S_ESC;
                end else begin
                    o_cmd.op = OP_INIT;
                    n_state  = S_SX_MUL;
                end
            end
            S_SX_MUL: begin
                o_cmd.mul_sel = MUL_SX;
                n_state       = S_SX;
            end
            S_SX: begin
                o_cmd.op = OP_SIDEX;
                n_state  = S_SY_MUL;
            end
            S_SY_MUL: begin
                o_cmd.mul_sel = MUL_SY;
                n_state       = S_SY;
            end
            S_SY: begin
                o_cmd.op = OP_SIDEY;
                n_state  = S_STEP;
            end
            S_STEP: begin
                o_cmd.op = OP_STEP;
                n_state  = S_CHECK;
            end
            S_CHECK: begin
                // The map read of the new cell is registered during this state.
                n_state = i_stat.in_bounds ? S_TEST : S_ESC;
            end
            S_TEST: begin
                if (i_stat.cell_hit) begin
                    n_state = S_DIST;
                end else if (i_stat.steps_done) begin
                    n_state = S_ESC;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_DIST: begin
                o_cmd.op = OP_DIST;
                n_state  = S_COLH_GO;
            end
            S_COLH_GO: begin
                if (i_stat.dist_zero) begin
                    o_cmd.op = OP_COLH;
                    n_state  = S_WALL_MUL;
                end else begin
                    o_cmd.op      = OP_DIV_START;
                    o_cmd.div_sel = DIV_COLH;
                    n_state       = S_COLH_WAIT;
                end
            end
            S_COLH_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.op = OP_COLH;
                    n_state  = S_WALL_MUL;
                end
            end
            S_WALL_MUL: begin
                o_cmd.mul_sel = MUL_WALL;
                n_state       = S_WALL;
            end
            S_WALL: begin
                o_cmd.op = OP_WALL;
                n_state  = S_TSTEP_GO;
            end
            S_TSTEP_GO: begin
                if (i_stat.colh_zero) begin
                    o_cmd.op = OP_TSTEP;
                    n_state  = S_TP_MUL;
                end else begin
                    o_cmd.op      = OP_DIV_START;
                    o_cmd.div_sel = DIV_STEP;
                    n_state       = S_TSTEP_WAIT;
                end
            end
            S_TSTEP_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.op = OP_TSTEP;
                    n_state  = S_TP_MUL;
                end
            end
            S_TP_MUL: begin
                o_cmd.mul_sel = MUL_TP;
                n_state       = S_TP;
            end
            S_TP: begin
                o_cmd.op = OP_TP;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_LOAD_HIT;
                    n_state  = S_IDLE;
                end
            end
            S_ESC: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_LOAD_ESC;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register; reset starts the map clearing sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: sv/dda_raycast_column_unit.sv
// Top level of the grid ray caster: controller plus datapath.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_ready  | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready| o_out_data (t_out_item)
//  cfg     | input     | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// A cell write item is written to the map straight from the idle state. A cast item
// runs through the controller sequence, with up to five divisions in the shared
// one-bit-per-cycle divider and a step, a map read and a test for each grid cell
// walked; an escape ends sooner. A held result adds stalls.
// After reset a clearing sweep writes zero to all MAP_DIM*MAP_DIM map cells, one
// per cycle, before the first item is taken.
// A finished result waits in the output register while the next item is accepted.
`default_nettype none

module dda_raycast_column_unit
    import drc_pkg::*;
#(
    parameter int MAP_DIM   = MAP_DIM_DEF,
    parameter int TEX_SIZE  = TEX_SIZE_DEF,
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    // Sequencer.
    drc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_opcode (i_in_data.opcode),
        .i_stat      (stat),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd)
    );

    // Arithmetic, map memory and result register.
    drc_dpath #(
        .MAP_DIM   (MAP_DIM),
        .TEX_SIZE  (TEX_SIZE),
        .MAX_STEPS (MAX_STEPS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

`default_nettype wire

FILE: test/dda_raycast_column_unit_test.sv
// Self-checking testbench for the grid ray caster: map writes, casts, config sweeps.
`default_nettype none

module dda_raycast_column_unit_test
    import drc_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 900;

    // Predicts cast results and keeps the results still owed by the block.
    class column_scoreboard;
        byte unsigned map_cells [MAP_DIM_DEF][MAP_DIM_DEF];
        longint       pos_x, pos_y, dir_x, dir_y, plane_x, plane_y, width, height;
        t_out_item    owed_q[$];
        int           errors;
        int           results;

        function new();
            foreach (map_cells[i, j]) map_cells[i][j] = 0;
            pos_x = 786432;
            pos_y = 786432;
            dir_x = -16384;
            dir_y = 0;
            plane_x = 0;
            plane_y = 10813;
            width = 640;
            height = 480;
            errors = 0;
            results = 0;
        endfunction

        function longint sext16(logic [CFG_DATA_W-1:0] v);
            return longint'($signed(v[15:0]));
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_POS_X:   pos_x = v[POS_W-1:0];
                CFG_POS_Y:   pos_y = v[POS_W-1:0];
                CFG_DIR_X:   dir_x = sext16(v);
                CFG_DIR_Y:   dir_y = sext16(v);
                CFG_PLANE_X: plane_x = sext16(v);
                CFG_PLANE_Y: plane_y = sext16(v);
                CFG_WIDTH:   width = v[SIZE_W-1:0];
                CFG_HEIGHT:  height = v[SIZE_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clamp_size(longint v);
            if (v < 1) return 1;
            if (v > 1024) return 1024;
            return v;
        endfunction

        // Distance along the ray between two grid lines of one axis.
        function longint ray_delta(longint r);
            longint q;
            if (r == 0) return longint'(DIST_MAX);
            q = (longint'(1) << 30) / (r < 0 ? -r : r);
            return q > longint'(DIST_MAX) ? longint'(DIST_MAX) : q;
        endfunction

        function t_out_item cast_column(logic [COL_W-1:0] col);
            longint    w, h, cam, rdx, rdy, dx, dy, mx, my, fx, fy, sx, sy;
            longint    wdist, colh, ds, de, wall, frac, texc, tstep, tp;
            int        sgx, sgy, side, n;
            bit        hit;
            int        cval;
            t_out_item r;
            r = '0;
            r.out_column = col;
            side = 0;
            hit = 0;
            cval = 0;
            w = clamp_size(width);
            h = clamp_size(height);
            cam = ((longint'(col) * 2) << 14) / w - 16384;
            rdx = dir_x + ((plane_x * cam) >>> 14);
            rdy = dir_y + ((plane_y * cam) >>> 14);
            dx = ray_delta(rdx);
            dy = ray_delta(rdy);
            mx = pos_x >> 16;
            my = pos_y >> 16;
            if (mx >= MAP_DIM_DEF || my >= MAP_DIM_DEF) begin
                r.escaped = 1'b1;
                return r;
            end
            fx = pos_x & 16'hFFFF;
            fy = pos_y & 16'hFFFF;
            if (rdx < 0) begin sgx = -1; sx = (fx * dx) >> 16; end
            else begin sgx = 1; sx = ((65536 - fx) * dx) >> 16; end
            if (rdy < 0) begin sgy = -1; sy = (fy * dy) >> 16; end
            else begin sgy = 1; sy = ((65536 - fy) * dy) >> 16; end
            // Grid walk; a tie steps in y.
            for (n = 0; n < MAX_STEPS_DEF; n++) begin
                if (sx < sy) begin sx += dx; mx += sgx; side = 0; end
                else begin sy += dy; my += sgy; side = 1; end
                if (mx < 0 || mx >= MAP_DIM_DEF || my < 0 || my >= MAP_DIM_DEF) break;
                cval = map_cells[mx][my];
                if (cval != 0) begin hit = 1; break; end
            end
            if (!hit) begin
                r.escaped = 1'b1;
                return r;
            end
            wdist = (side == 0) ? sx - dx : sy - dy;
            if (wdist > longint'(DIST_MAX)) wdist = longint'(DIST_MAX);
            if (wdist == 0) colh = longint'(COLH_MAX);
            else begin
                colh = (h << 16) / wdist;
                if (colh > longint'(COLH_MAX)) colh = longint'(COLH_MAX);
            end
            ds = h / 2 - colh / 2;
            if (ds < 0) ds = 0;
            de = colh / 2 + h / 2;
            if (de >= h) de = h - 1;
            // Hit point along the other axis, then the mirrored texture column.
            if (side == 0) wall = pos_y + ((wdist * rdy) >>> 14);
            else wall = pos_x + ((wdist * rdx) >>> 14);
            frac = wall & 16'hFFFF;
            texc = (frac * TEX_SIZE_DEF) >> 16;
            if ((side == 0 && rdx > 0) || (side == 1 && rdy < 0))
                texc = TEX_SIZE_DEF - texc - 1;
            if (colh == 0) tstep = longint'(STEP_MAX);
            else begin
                tstep = (longint'(TEX_SIZE_DEF) << 16) / colh;
                if (tstep > longint'(STEP_MAX)) tstep = longint'(STEP_MAX);
            end
            tp = (ds - h / 2 + colh / 2) * tstep;
            if (tp > 64'hFFFF_FFFF) tp = 64'hFFFF_FFFF;
            r.hit_x = mx[CIDX_W-1:0];
            r.hit_y = my[CIDX_W-1:0];
            r.hit_side = side[0];
            r.tex_index = CVAL_W'(cval - 1);
            r.tex_column = texc[TEXC_W-1:0];
            r.span_start = ds[ROW_W-1:0];
            r.span_end = de[ROW_W-1:0];
            r.wall_distance = wdist[DELTA_W-1:0];
            r.tex_step = tstep[STEP_W-1:0];
            r.tex_start = tp[TP_W-1:0];
            return r;
        endfunction

        // An accepted input item: update the map or owe one result.
        function void note_input(t_in_item it);
            if (it.opcode == OPC_WRITE) begin
                if (it.cell_x < MAP_DIM_DEF && it.cell_y < MAP_DIM_DEF)
                    map_cells[it.cell_x][it.cell_y] = it.cell_value;
            end else begin
                owed_q.push_back(cast_column(it.column));
            end
        endfunction

        function void cmp(string name, longint unsigned e, longint unsigned a);
            if (e != a) begin
                $error("%s mismatch: expected %0d, actual %0d", name, e, a);
                errors++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            results++;
            if (owed_q.size() == 0) begin
                $error("result for column %0d arrived with none expected", got.out_column);
                errors++;
                return;
            end
            e = owed_q.pop_front();
            cmp("out_column", e.out_column, got.out_column);
            cmp("hit_x", e.hit_x, got.hit_x);
            cmp("hit_y", e.hit_y, got.hit_y);
            cmp("hit_side", e.hit_side, got.hit_side);
            cmp("tex_index", e.tex_index, got.tex_index);
            cmp("tex_column", e.tex_column, got.tex_column);
            cmp("span_start", e.span_start, got.span_start);
            cmp("span_end", e.span_end, got.span_end);
            cmp("wall_distance", e.wall_distance, got.wall_distance);
            cmp("tex_step", e.tex_step, got.tex_step);
            cmp("tex_start", e.tex_start, got.tex_start);
            cmp("escaped", e.escaped, got.escaped);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_item              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_item             o_out_data;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    column_scoreboard sb;
    int  items_sent;
    int  cfg_writes;
    int  quiet_cycles;
    bit  send_idle;
    bit  recv_idle;
    bit  hold_request;

    dda_raycast_column_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Watchdog on cycles with no item moving on any channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result receiver with random stalls and one long hold.
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            n = recv_idle ? $urandom_range(0, 4) : 0;
            if (hold_request) begin
                hold_request = 1'b0;
                n = LONG_HOLD;
            end
            if (n > 0) begin
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_result(o_out_data);
        end
    end

    // Offers one item after a random gap and waits for it to be taken.
    task automatic send_item(t_in_item it);
        int gap;
        gap = send_idle ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(it);
        items_sent++;
    endtask

    task automatic send_write(int x, int y, int v);
        t_in_item it;
        it = t_in_item'(($bits(t_in_item))'($urandom));
        it.opcode = OPC_WRITE;
        it.cell_x = CIDX_W'(x);
        it.cell_y = CIDX_W'(y);
        it.cell_value = CVAL_W'(v);
        send_item(it);
    endtask

    task automatic send_cast(int col);
        t_in_item it;
        it = t_in_item'(($bits(t_in_item))'($urandom));
        it.opcode = OPC_CAST;
        it.column = COL_W'(col);
        send_item(it);
    endtask

    // Waits until every owed result is back and the block has settled.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.owed_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.write_reg(idx, v);
        cfg_writes++;
    endtask

    // Signed Q2.14 component with noise in the unused upper bits.
    function automatic logic [CFG_DATA_W-1:0] dir_word(int v);
        return {16'($urandom_range(0, 65535)), v[15:0]};
    endfunction

    function automatic int pick_size();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 1;
            2: return 1024;
            3: return 2047;
            default: return $urandom_range(1, 1024);
        endcase
    endfunction

    function automatic int pick_dir();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return -32768;
            2: return 32767;
            3: return int'($urandom_range(0, 65535)) - 32768;
            default: return int'($urandom_range(0, 32768)) - 16384;
        endcase
    endfunction

    function automatic int pick_pos();
        if ($urandom_range(0, 5) == 0) return $urandom_range(0, 2097151);
        return ($urandom_range(1, 30) << 16) | $urandom_range(0, 65535);
    endfunction

    task automatic random_config();
        write_cfg(CFG_POS_X, {11'($urandom_range(0, 2047)), 21'(pick_pos())});
        write_cfg(CFG_POS_Y, {11'($urandom_range(0, 2047)), 21'(pick_pos())});
        write_cfg(CFG_DIR_X, dir_word(pick_dir()));
        write_cfg(CFG_DIR_Y, dir_word(pick_dir()));
        write_cfg(CFG_PLANE_X, dir_word(pick_dir()));
        write_cfg(CFG_PLANE_Y, dir_word(pick_dir()));
        write_cfg(CFG_WIDTH, {21'($urandom_range(0, 1048575)), 11'(pick_size())});
        write_cfg(CFG_HEIGHT, {21'($urandom_range(0, 1048575)), 11'(pick_size())});
    endtask

    initial begin
        int col;
        sb = new();
        items_sent = 0;
        cfg_writes = 0;
        quiet_cycles = 0;
        send_idle = 1'b1;
        recv_idle = 1'b1;
        hold_request = 1'b0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        i_out_ready <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty map escapes, extreme cell values, wide columns.
        send_cast(0);
        send_cast(1023);
        send_write(11, 12, 255);
        send_cast(320);
        send_cast(0);
        send_cast(639);
        send_cast(1023);
        send_write(11, 12, 1);
        send_cast(320);
        send_write(11, 12, 0);
        send_cast(320);
        send_write(11, 12, 7);
        drain();
        // A zero ray y component and a zero wall distance from an exact grid position.
        write_cfg(CFG_PLANE_Y, dir_word(0));
        send_cast(100);
        drain();
        write_cfg(4'd15, $urandom);
        write_cfg(CFG_WIDTH, 32'd0);
        write_cfg(CFG_HEIGHT, 32'd2047);
        write_cfg(CFG_PLANE_Y, dir_word(32767));
        write_cfg(CFG_DIR_X, dir_word(-32768));
        send_cast(0);
        send_cast(1023);
        drain();

        // Closed border so most rays find a wall.
        for (int i = 0; i < MAP_DIM_DEF; i++) begin
            send_write(i, 0, $urandom_range(1, 255));
            send_write(i, 31, $urandom_range(1, 255));
            send_write(0, i, $urandom_range(1, 255));
            send_write(31, i, $urandom_range(1, 255));
        end
        drain();

        // Random phases, each under a fresh configuration.
        for (int phase = 0; phase < 8; phase++) begin
            random_config();
            if (phase == 2) hold_request = 1'b1;
            for (int k = 0; k < 160; k++) begin
                if (k % 40 == 0) begin
                    send_idle = ($urandom_range(0, 3) != 0);
                    recv_idle = ($urandom_range(0, 3) != 0);
                end
                if (k == 80) drain();
                if ($urandom_range(0, 9) < 6) begin
                    col = ($urandom_range(0, 6) != 0)
                        ? $urandom_range(0, 32'(sb.clamp_size(sb.width) - 1))
                        : $urandom_range(0, 1023);
                    send_cast(col);
                end else begin
                    send_write($urandom_range(0, 31), $urandom_range(0, 31),
                               ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 255));
                end
            end
            drain();
        end

        // Back to the reset view for a final check.
        write_cfg(CFG_POS_X, 32'd786432);
        write_cfg(CFG_POS_Y, 32'd786432);
        write_cfg(CFG_DIR_X, dir_word(-16384));
        write_cfg(CFG_DIR_Y, dir_word(0));
        write_cfg(CFG_PLANE_X, dir_word(0));
        write_cfg(CFG_PLANE_Y, dir_word(10813));
        write_cfg(CFG_WIDTH, 32'd640);
        write_cfg(CFG_HEIGHT, 32'd480);
        for (int k = 0; k < 20; k++) send_cast($urandom_range(0, 639));
        drain();
        repeat (100) @(posedge i_clk);

        $display("Covered %0d items (%0d casts checked) under %0d register writes.",
                 items_sent, sb.results, cfg_writes);
        if (sb.errors == 0 && sb.owed_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
sv/drc_pkg.sv
sv/drc_ram.sv
sv/drc_div.sv
sv/drc_dpath.sv
sv/drc_ctrl.sv
sv/dda_raycast_column_unit.sv
test/dda_raycast_column_unit_test.sv
